/* hdl/assert_macros.svh */
// Assertion macros shared by the detector RTL.
// Expects signals clk and rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CLMD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define CLMD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* hdl/clmd_pkg.sv */
// Shared constants and types for the cross local maximum detector.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package clmd_pkg;

  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int WIDTH_REG_BITS  = 11;
  localparam int HEIGHT_REG_BITS = 16;
  localparam int CFG_DATA_BITS   = 16;
  localparam int ROW_BITS        = 16;
  localparam int OUT_COL_BITS    = 10;

  localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = WIDTH_REG_BITS'(1024);
  localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = HEIGHT_REG_BITS'(1024);

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

/* hdl/clmd_line_store.sv */
// Ping-pong pair of row stores, banked by row parity.
// Each bank: one write port, two registered read ports (column and column + 1).
`timescale 1ns / 1ps
`default_nettype none

module clmd_line_store #(
  parameter int DEPTH     = 1024,
  parameter int DATA_BITS = 16
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic                           wr_bank,
  input  logic [$clog2(DEPTH)-1:0]       wr_addr,
  input  logic [DATA_BITS-1:0]           wr_data,
  input  logic                           rd_en,
  input  logic [$clog2(DEPTH)-1:0]       rd_addr,
  output logic [1:0][DATA_BITS-1:0]      rd_here,
  output logic [1:0][DATA_BITS-1:0]      rd_next
);

  localparam int ADDR_BITS = $clog2(DEPTH);

  logic [DATA_BITS-1:0] mem0 [DEPTH];
  logic [DATA_BITS-1:0] mem1 [DEPTH];
  logic [ADDR_BITS-1:0] rd_addr_nx;
  logic [DATA_BITS-1:0] here0, here1, next0, next1;

  assign rd_addr_nx = rd_addr + 1'b1;

  // read-first: a read at the written address returns the old entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      here0 <= mem0[rd_addr];
      next0 <= mem0[rd_addr_nx];
    end
    if (wr_en && !wr_bank) begin
      mem0[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      here1 <= mem1[rd_addr];
      next1 <= mem1[rd_addr_nx];
    end
    if (wr_en && wr_bank) begin
      mem1[wr_addr] <= wr_data;
    end
  end

  assign rd_here = {here1, here0};
  assign rd_next = {next1, next0};

endmodule

`default_nettype wire

/* hdl/cross_local_maximum_detect.sv */
// Timing: a pixel's result is judged at the next accepted beat after its window
//   completes and is registered at the output on that beat.
// Throughput: one beat per cycle while in_ready is high; set by the single compare pass
//   and the two read ports of each row bank.
// Reset: synchronous; clears counters and pending result, size returns to 1024 x 1024.
//   Row stores are not cleared. Uses clmd_pkg, clmd_line_store, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cross_local_maximum_detect #(
  parameter int MAX_WIDTH   = clmd_pkg::DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = clmd_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  clmd_pkg::cfg_reg_t                   cfg_index,
  input  logic [clmd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  input  logic                                 flush,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 peak,
  output logic [clmd_pkg::ROW_BITS-1:0]        out_row,
  output logic [clmd_pkg::OUT_COL_BITS-1:0]    out_col,
  output logic                                 frame_end
);

  import clmd_pkg::*;

  localparam int COL_BITS = $clog2(MAX_WIDTH);

  logic [WIDTH_REG_BITS-1:0]  width_reg;
  logic [HEIGHT_REG_BITS-1:0] height_reg;
  logic [COL_BITS-1:0]        w_last;
  logic [ROW_BITS-1:0]        h_last;

  logic [ROW_BITS-1:0] row_cnt, row_e, row_cnt_next;
  logic [COL_BITS-1:0] col_cnt, col_e, col_cnt_next;
  logic [ROW_BITS-1:0] opos_row, opos_row_e, opos_row_next;
  logic [COL_BITS-1:0] opos_col, opos_col_e, opos_col_next;

  logic                          win_valid;
  logic [ROW_BITS-1:0]           win_row;
  logic [COL_BITS-1:0]           win_col;
  logic signed [SAMPLE_BITS-1:0] win_down;
  logic                          win_bank;
  logic signed [SAMPLE_BITS-1:0] left_smp;

  logic cfg_fire, in_fire, win_last, drain, norm, cap;
  logic [COL_BITS-1:0] cap_col;

  logic [1:0][SAMPLE_BITS-1:0] rd_here, rd_next;
  logic signed [SAMPLE_BITS-1:0] centre, up_smp, right_smp;
  logic strict, ok_up, ok_left, ok_right, ok_down;

  // effective size, clamped
  always_comb begin
    if (width_reg < WIDTH_REG_BITS'(2)) begin
      w_last = COL_BITS'(1);
    end else if (32'(width_reg) > MAX_WIDTH) begin
      w_last = COL_BITS'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_BITS'(width_reg - 1'b1);
    end
    if (height_reg < HEIGHT_REG_BITS'(2)) begin
      h_last = ROW_BITS'(1);
    end else begin
      h_last = height_reg - 1'b1;
    end
  end

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;
  assign in_ready  = !cfg_valid && !(win_valid && out_valid && !out_ready);
  assign in_fire   = in_valid && in_ready;

  // last pixel's result leaving restarts the frame within the same beat
  assign win_last   = win_valid && (win_row == h_last) && (win_col == w_last);
  assign row_e      = win_last ? '0 : row_cnt;
  assign col_e      = win_last ? '0 : col_cnt;
  assign opos_row_e = win_last ? '0 : opos_row;
  assign opos_col_e = win_last ? '0 : opos_col;

  assign drain   = row_e > h_last;
  assign norm    = !drain && !flush;
  assign cap     = in_fire && (drain ? (opos_row_e == h_last) : (norm && row_e != '0));
  assign cap_col = drain ? opos_col_e : col_e;

  always_comb begin
    row_cnt_next  = row_e;
    col_cnt_next  = col_e;
    opos_row_next = opos_row_e;
    opos_col_next = opos_col_e;
    if (norm) begin
      if (col_e == w_last) begin
        col_cnt_next = '0;
        row_cnt_next = row_e + 1'b1;
      end else begin
        col_cnt_next = col_e + 1'b1;
      end
    end
    if (cap) begin
      if (opos_col_e == w_last) begin
        opos_col_next = '0;
        opos_row_next = opos_row_e + 1'b1;
      end else begin
        opos_col_next = opos_col_e + 1'b1;
      end
    end
  end

  clmd_line_store #(
    .DEPTH     (MAX_WIDTH),
    .DATA_BITS (SAMPLE_BITS)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (in_fire && norm),
    .wr_bank (row_e[0]),
    .wr_addr (col_e),
    .wr_data (sample),
    .rd_en   (cap),
    .rd_addr (cap_col),
    .rd_here (rd_here),
    .rd_next (rd_next)
  );

  assign centre    = rd_here[win_bank];
  assign right_smp = rd_next[win_bank];
  assign up_smp    = rd_here[!win_bank];

  always_comb begin
    strict   = (win_row != '0) && (win_row != h_last) && (win_col == w_last);
    ok_up    = (win_row == '0)    || (strict ? (centre > up_smp)    : (centre >= up_smp));
    ok_left  = (win_col == '0)    || (strict ? (centre > left_smp)  : (centre >= left_smp));
    ok_right = (win_col == w_last) || (strict ? (centre > right_smp) : (centre >= right_smp));
    ok_down  = (win_row == h_last) || (strict ? (centre > win_down)  : (centre >= win_down));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
      row_cnt    <= '0;
      col_cnt    <= '0;
      opos_row   <= '0;
      opos_col   <= '0;
      win_valid  <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_REG_BITS-1:0];
        REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_REG_BITS-1:0];
        default: ;
      endcase
      row_cnt   <= '0;
      col_cnt   <= '0;
      opos_row  <= '0;
      opos_col  <= '0;
      win_valid <= 1'b0;
    end else if (in_fire) begin
      row_cnt   <= row_cnt_next;
      col_cnt   <= col_cnt_next;
      opos_row  <= opos_row_next;
      opos_col  <= opos_col_next;
      win_valid <= cap;
    end
  end

  // window held until the next beat judges it
  always_ff @(posedge clk) begin
    if (cap) begin
      win_row  <= drain ? h_last : row_e - 1'b1;
      win_col  <= cap_col;
      win_down <= sample;
      win_bank <= drain ? h_last[0] : !row_e[0];
      left_smp <= centre;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && win_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && win_valid) begin
      peak      <= ok_up && ok_left && ok_right && ok_down;
      out_row   <= win_row;
      out_col   <= OUT_COL_BITS'(win_col);
      frame_end <= win_last;
    end
  end

  `CLMD_ASSERT(a_no_overrun, (in_fire && win_valid) |-> (!out_valid || out_ready), "result register overrun")
  `CLMD_ASSERT_NEXT(a_frame_restart, in_fire && win_last, opos_row == '0 && opos_col == '0 && !win_valid, "frame did not restart")
  `CLMD_ASSERT(a_win_inside, win_valid |-> (win_col <= w_last && win_row <= h_last), "window outside image")
  `CLMD_ASSERT(a_out_source, $rose(out_valid) |-> $past(in_fire && win_valid), "result without source beat")

endmodule

`default_nettype wire

/* tb/cross_local_maximum_detect_checker.sv */
// Checker for the cross local maximum detector: watches the config, sample and
// result channels, predicts each judged pixel and compares it with the block.
// Depends on clmd_pkg.
`timescale 1ns / 1ps

module cross_local_maximum_detect_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  clmd_pkg::cfg_reg_t                 cfg_index,
  input  logic [clmd_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [clmd_pkg::DEF_SAMPLE_BITS-1:0] sample,
  input  logic                               flush,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic                               peak,
  input  logic [clmd_pkg::ROW_BITS-1:0]      out_row,
  input  logic [clmd_pkg::OUT_COL_BITS-1:0]  out_col,
  input  logic                               frame_end,
  output int                                 fail_count,
  output int                                 pending
);
  import clmd_pkg::*;

  localparam int MAXW = DEF_MAX_WIDTH;
  localparam int SB   = DEF_SAMPLE_BITS;

  typedef logic signed [SB-1:0] elev_t;

  typedef struct packed {
    logic                    peak;
    logic [ROW_BITS-1:0]     row;
    logic [OUT_COL_BITS-1:0] col;
    logic                    last;
  } verdict_t;

  verdict_t verdict_q[$];

  logic [WIDTH_REG_BITS-1:0]  width_reg;
  logic [HEIGHT_REG_BITS-1:0] height_reg;
  elev_t older_line [MAXW];
  elev_t newer_line [MAXW];
  elev_t nb_up, nb_left, nb_mid, nb_right, nb_down;
  bit held;
  int unsigned held_row, held_col;
  int unsigned in_row, in_col, next_pos;
  int errors = 0;

  function automatic int unsigned eff_w();
    int unsigned w;
    w = width_reg;
    if (w < 2) w = 2;
    if (w > MAXW) w = MAXW;
    return w;
  endfunction

  function automatic int unsigned eff_h();
    int unsigned h;
    h = height_reg;
    if (h < 2) h = 2;
    return h;
  endfunction

  function automatic void new_frame();
    in_row = 0;
    in_col = 0;
    next_pos = 0;
    held = 0;
  endfunction

  function automatic bit clears(elev_t c, elev_t n, bit strict);
    return strict ? (c > n) : (c >= n);
  endfunction

  function automatic bit held_is_peak(int unsigned w, int unsigned h);
    bit strict, ok;
    // right column of an interior row needs a strict margin
    strict = held_row > 0 && held_row < h - 1 && held_col == w - 1;
    ok = 1'b1;
    if (held_row > 0) ok &= clears(nb_mid, nb_up, strict);
    if (held_col > 0) ok &= clears(nb_mid, nb_left, strict);
    if (held_col < w - 1) ok &= clears(nb_mid, nb_right, strict);
    if (held_row < h - 1) ok &= clears(nb_mid, nb_down, strict);
    return ok;
  endfunction

  function automatic void hold_window(int unsigned row, int unsigned col, elev_t u,
                                      elev_t l, elev_t m, elev_t r, elev_t d);
    nb_up = u;
    nb_left = l;
    nb_mid = m;
    nb_right = r;
    nb_down = d;
    held_row = row;
    held_col = col;
    held = 1;
    next_pos++;
  endfunction

  function automatic void take_beat(elev_t s, logic f);
    int unsigned w, h, base, c, r;
    elev_t lft, rgt;
    verdict_t v;
    w = eff_w();
    h = eff_h();
    if (held) begin
      v.peak = held_is_peak(w, h);
      v.row = held_row[ROW_BITS-1:0];
      v.col = held_col[OUT_COL_BITS-1:0];
      v.last = held_row == h - 1 && held_col == w - 1;
      verdict_q.insert(verdict_q.size(), v);
      held = 0;
      if (v.last) new_frame();
    end
    if (in_row >= h) begin
      // whole frame is in: walk the last row, sample value ignored
      base = (h - 1) * w;
      if (next_pos >= base && next_pos < base + w) begin
        c = next_pos - base;
        lft = c > 0 ? newer_line[c-1] : '0;
        rgt = c + 1 < w ? newer_line[c+1] : '0;
        hold_window(h - 1, c, older_line[c], lft, newer_line[c], rgt, '0);
      end
    end else if (!f) begin
      r = in_row;
      c = in_col;
      if (c >= w) c = 0;
      if (r >= 1) begin
        lft = c > 0 ? older_line[c-1] : '0;
        rgt = c + 1 < w ? newer_line[c+1] : '0;
        hold_window(r - 1, c, older_line[c], lft, newer_line[c], rgt, s);
      end
      older_line[c] = newer_line[c];
      newer_line[c] = s;
      c++;
      if (c >= w) begin
        c = 0;
        in_row = r + 1;
      end
      in_col = c;
    end
  endfunction

  always @(posedge clk) begin
    verdict_t v;
    if (rst) begin
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      for (int i = 0; i < MAXW; i++) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
      nb_up = '0;
      nb_left = '0;
      nb_mid = '0;
      nb_right = '0;
      nb_down = '0;
      held_row = 0;
      held_col = 0;
      new_frame();
      verdict_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("result beat with nothing expected: row %0d col %0d", out_row, out_col);
          errors++;
        end else begin
          v = verdict_q.pop_front();
          if (peak !== v.peak) begin
            $error("peak: expected %0d, actual %0d", v.peak, peak);
            errors++;
          end
          if (out_row !== v.row) begin
            $error("out_row: expected %0d, actual %0d", v.row, out_row);
            errors++;
          end
          if (out_col !== v.col) begin
            $error("out_col: expected %0d, actual %0d", v.col, out_col);
            errors++;
          end
          if (frame_end !== v.last) begin
            $error("frame_end: expected %0d, actual %0d", v.last, frame_end);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_IMAGE_WIDTH) width_reg = cfg_data[WIDTH_REG_BITS-1:0];
        else height_reg = cfg_data[HEIGHT_REG_BITS-1:0];
        new_frame();
      end
      if (in_valid && in_ready) take_beat(sample, flush);
    end
    fail_count <= errors;
    pending <= verdict_q.size();
  end

endmodule

/* tb/cross_local_maximum_detect_tb.sv */
// Top of the cross local maximum detector testbench: clock, reset, raster frame
// stimulus with random stalls on both channels, and the final verdict.
// Depends on clmd_pkg, cross_local_maximum_detect and its checker.
`timescale 1ns / 1ps

module cross_local_maximum_detect_tb;
  import clmd_pkg::*;

  localparam int SB = DEF_SAMPLE_BITS;
  localparam int ITEMS = 1450;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_reg_t cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SB-1:0] sample = '0;
  logic flush = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic peak;
  logic [ROW_BITS-1:0] out_row;
  logic [OUT_COL_BITS-1:0] out_col;
  logic frame_end;
  int fail_count;
  int pending;

  int unsigned cur_w = 1024;
  int unsigned cur_h = 1024;
  bit head_start = 0;
  bit calm = 0;
  int sent = 0;
  logic signed [SB-1:0] level = '0;
  int unsigned spread = 0;

  always #5 clk = ~clk;

  cross_local_maximum_detect uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .sample(sample), .flush(flush),
    .out_valid(out_valid), .out_ready(out_ready), .peak(peak), .out_row(out_row),
    .out_col(out_col), .frame_end(frame_end)
  );

  cross_local_maximum_detect_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .sample(sample), .flush(flush),
    .out_valid(out_valid), .out_ready(out_ready), .peak(peak), .out_row(out_row),
    .out_col(out_col), .frame_end(frame_end), .fail_count(fail_count), .pending(pending)
  );

  // result side back-pressure
  initial begin
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  function automatic logic signed [SB-1:0] pick_sample();
    if ($urandom_range(0, 4) == 0) return SB'($urandom);
    return level + SB'($urandom_range(0, spread));
  endfunction

  task automatic put_item(input logic signed [SB-1:0] s, input logic f);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    flush <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_size(input int unsigned w_raw, input int unsigned h_raw);
    logic [CFG_DATA_BITS-1:0] wd;
    wd = CFG_DATA_BITS'($urandom);
    wd[WIDTH_REG_BITS-1:0] = w_raw[WIDTH_REG_BITS-1:0];
    settle();
    put_reg(REG_IMAGE_WIDTH, wd);
    put_reg(REG_IMAGE_HEIGHT, h_raw[HEIGHT_REG_BITS-1:0]);
    cfg_valid <= 1'b0;
    cur_w = w_raw & 32'h7ff;
    if (cur_w < 2) cur_w = 2;
    if (cur_w > DEF_MAX_WIDTH) cur_w = DEF_MAX_WIDTH;
    cur_h = h_raw & 32'hffff;
    if (cur_h < 2) cur_h = 2;
    head_start = 0;
  endtask

  // one frame of samples with stray flushes, then the drain of the last row;
  // cut stops part way so that the next config write restarts the frame
  task automatic run_frame(input bit cut);
    int unsigned total, stop;
    bit last_f;
    total = cur_w * cur_h;
    stop = cut ? $urandom_range(1, total - 1 > 120 ? 120 : total - 1) : total;
    level = SB'($urandom);
    spread = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 300);
    for (int unsigned k = head_start; k < stop; k++) begin
      if ($urandom_range(0, 11) == 0) put_item(pick_sample(), 1'b1);
      put_item(pick_sample(), 1'b0);
    end
    if (!cut) begin
      last_f = 1'b1;
      for (int unsigned k = 0; k <= cur_w; k++) begin
        last_f = $urandom_range(0, 1);
        put_item(pick_sample(), last_f);
      end
      head_start = !last_f;
    end
  endtask

  initial begin
    int unsigned w_raw, h_raw;
    bit cut;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // flush right after reset: nothing pending
    put_item('0, 1'b1);
    set_size(2, 2);
    put_item(16'sh7fff, 1'b0);
    put_item(16'sh8000, 1'b0);
    put_item(16'sh8000, 1'b0);
    put_item(16'sh7fff, 1'b0);
    put_item('0, 1'b1);
    put_item(16'sh0000, 1'b0);
    // frame end beat carries pixel (0,0) of the next frame
    put_item(16'sh8000, 1'b0);
    put_item(16'sh8000, 1'b0);
    put_item('0, 1'b1);
    put_item(16'sh8000, 1'b0);
    put_item(16'sh8000, 1'b0);
    put_item('0, 1'b1);
    put_item('0, 1'b1);
    put_item('0, 1'b1);
    // flat 2x3: right pixel of the middle row fails the strict test
    set_size(2, 3);
    repeat (6) put_item(16'sh0005, 1'b0);
    repeat (3) put_item('0, 1'b1);

    // size extremes and clamping
    set_size(1024, 2);
    run_frame(1'b1);
    set_size(2, 65535);
    run_frame(1'b1);
    set_size(2047, 0);
    run_frame(1'b1);
    set_size(1, 1);
    run_frame(1'b0);
    set_size(0, 2);
    run_frame(1'b0);

    while (sent < ITEMS) begin
      case ($urandom_range(0, 9))
        0: w_raw = $urandom_range(0, 1);
        1: w_raw = $urandom_range(11, 40);
        2: w_raw = $urandom_range(1024, 2047);
        default: w_raw = $urandom_range(2, 10);
      endcase
      case ($urandom_range(0, 9))
        0: h_raw = $urandom_range(0, 1);
        1: h_raw = $urandom_range(9, 30);
        2: h_raw = $urandom_range(1025, 65535);
        default: h_raw = $urandom_range(2, 8);
      endcase
      set_size(w_raw, h_raw);
      repeat ($urandom_range(1, 3)) begin
        calm = sent >= ITEMS - 150;
        cut = cur_w * cur_h > 150 || $urandom_range(0, 9) == 0;
        run_frame(cut);
        if (cut) break;
      end
    end

    calm = 1;
    settle();
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
